// File: src/arpc_pkg.sv
// Shared types and constants for the ARP cache core.
// Used by all modules in src; no dependencies.
package arpc_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_QUEUE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_QACK   = 3'd1,
    KIND_IACK   = 3'd2,
    KIND_RESEND = 3'd3,
    KIND_GIVEUP = 3'd4,
    KIND_TICK   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_CACHE,
    ST_REPLY,
    ST_TPEND
  } state_e;

  localparam logic [0:0] REG_TIMEOUT  = 1'd0;
  localparam logic [0:0] REG_MAXTRIES = 1'd1;

  localparam logic [15:0] TIMEOUT_RST  = 16'd15;
  localparam logic [7:0]  MAXTRIES_RST = 8'd5;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic        hit;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        status;
    logic        last;
  } result_t;

endpackage

// File: src/arpc_regs.sv
// APB-style configuration registers: timeout and max tries.
// Depends on arpc_pkg.
module arpc_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] timeout_o,
  output logic [7:0]  max_tries_o
);
  logic [15:0] timeout_q;
  logic [7:0]  max_tries_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= arpc_pkg::TIMEOUT_RST;
      max_tries_q <= arpc_pkg::MAXTRIES_RST;
    end else if (wr) begin
      if (paddr[2] == arpc_pkg::REG_TIMEOUT) timeout_q <= pwdata[15:0];
      else max_tries_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == arpc_pkg::REG_TIMEOUT) prdata = {16'd0, timeout_q};
      else prdata = {24'd0, max_tries_q};
    end
  end

  assign timeout_o   = timeout_q;
  assign max_tries_o = max_tries_q;
endmodule

// File: src/arp_cache_with_request_retry_core.sv
// ARP cache top level: control sequencer, cache and pending memories.
// Depends on arpc_pkg and arpc_regs.
//
// Command channel: start with cmd_i, ip_addr_i, mac_addr_i is taken when
// busy is low. Results appear for one cycle each with result_valid_o;
// last_o marks the final result of a command. The receiver cannot stall.
// Every command walks the memories one entry per cycle through a single
// registered read port, read-modify-write in the same step.
// busy stays high while the command walks, in this order:
//   lookup: the cache
//   queue:  the pending table
//   insert: the pending table, then the cache
//   tick:   the cache, then the pending table, with one resend or give-up
//           result per valid pending slot during the pending walk.
// The last result is registered; when it appears, busy is already low.
// Reset clears the valid bits and the clock and resets the registers; configuration
// may be written over the APB port while busy is low.
module arp_cache_with_request_retry_core #(
  parameter int CACHE_ENTRIES   = 64,
  parameter int PENDING_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] mac_addr_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic        hit_o,
  output logic [31:0] result_ip_o,
  output logic [47:0] result_mac_o,
  output logic        status_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int IW = (CW > PW) ? CW : PW;

  logic [15:0] timeout;
  logic [7:0]  max_tries;

  arpc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timeout_o(timeout), .max_tries_o(max_tries)
  );

  // memories
  logic [31:0] c_ip_mem  [CACHE_ENTRIES];
  logic [47:0] c_mac_mem [CACHE_ENTRIES];
  logic [31:0] c_add_mem [CACHE_ENTRIES];
  logic [31:0] p_ip_mem  [PENDING_ENTRIES];
  logic [7:0]  p_try_mem [PENDING_ENTRIES];
  logic [CACHE_ENTRIES-1:0]   c_vld_q, c_vld_d;
  logic [PENDING_ENTRIES-1:0] p_vld_q, p_vld_d;

  arpc_pkg::state_e state_q, state_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] ip_q, ip_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] now_q, now_d;
  logic [IW:0] idx_q, idx_d;     // address issued
  logic        rv_q, rv_d;       // read data valid for entry ridx_q
  logic [IW:0] ridx_q, ridx_d;
  logic        hit_q, hit_d, stat_q, stat_d, found_q, found_d;
  logic [47:0] fmac_q, fmac_d;
  logic [PW:0] free_q, free_d;   // matching or first free pending slot, PENDING_ENTRIES none
  logic [CW:0] cfree_q, cfree_d;
  arpc_pkg::result_t res_q, res_d;

  logic [31:0] rd_cip_q, rd_cadd_q, rd_pip_q;
  logic [47:0] rd_cmac_q;
  logic [7:0]  rd_ptry_q;

  logic        cw_en, pw_en;
  logic [CW-1:0] cw_a;
  logic [PW-1:0] pw_a;
  logic [31:0] cw_ip, cw_add, pw_ip;
  logic [47:0] cw_mac;
  logic [7:0]  pw_try;
  logic [CW-1:0] cr_a;
  logic [PW-1:0] pr_a;

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      c_ip_mem[cw_a]  <= cw_ip;
      c_mac_mem[cw_a] <= cw_mac;
      c_add_mem[cw_a] <= cw_add;
    end
    if (pw_en) begin
      p_ip_mem[pw_a]  <= pw_ip;
      p_try_mem[pw_a] <= pw_try;
    end
    rd_cip_q  <= c_ip_mem[cr_a];
    rd_cmac_q <= c_mac_mem[cr_a];
    rd_cadd_q <= c_add_mem[cr_a];
    rd_pip_q  <= p_ip_mem[pr_a];
    rd_ptry_q <= p_try_mem[pr_a];
  end

  assign busy = (state_q != arpc_pkg::ST_IDLE);
  assign cr_a = idx_q[CW-1:0];
  assign pr_a = idx_q[PW-1:0];

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; ip_d = ip_q; mac_d = mac_q; now_d = now_q;
    idx_d = idx_q; rv_d = 1'b0; ridx_d = idx_q; hit_d = hit_q; stat_d = stat_q;
    found_d = found_q; fmac_d = fmac_q; free_d = free_q; cfree_d = cfree_q;
    c_vld_d = c_vld_q; p_vld_d = p_vld_q;
    res_d = '0;
    cw_en = 1'b0; cw_a = '0; cw_ip = ip_q; cw_mac = mac_q; cw_add = now_q;
    pw_en = 1'b0; pw_a = '0; pw_ip = ip_q; pw_try = '0;
    case (state_q)
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d = cmd_i; ip_d = ip_addr_i; mac_d = mac_addr_i;
          idx_d = '0; hit_d = 1'b0; stat_d = 1'b0; found_d = 1'b0; fmac_d = '0;
          free_d = (PW+1)'(PENDING_ENTRIES); cfree_d = (CW+1)'(CACHE_ENTRIES);
          if (arpc_pkg::cmd_e'(cmd_i) == arpc_pkg::CMD_TICK) begin
            now_d = now_q + 32'd1;
            state_d = arpc_pkg::ST_CACHE;
          end else if (arpc_pkg::cmd_e'(cmd_i) == arpc_pkg::CMD_LOOKUP) begin
            state_d = arpc_pkg::ST_CACHE;
          end else begin
            state_d = arpc_pkg::ST_PEND;
          end
        end
      end
      arpc_pkg::ST_PEND: begin
        // queue/insert: scan pending table
        if (rv_q) begin
          if (p_vld_q[ridx_q[PW-1:0]] && rd_pip_q == ip_q && !found_q) begin
            found_d = 1'b1;
            free_d = ridx_q[PW:0];
          end else if (!p_vld_q[ridx_q[PW-1:0]] && !found_q &&
                       free_q == (PW+1)'(PENDING_ENTRIES)) begin
            free_d = ridx_q[PW:0];
          end
        end
        if (idx_q < (IW+1)'(PENDING_ENTRIES)) begin
          idx_d = idx_q + (IW+1)'(1); rv_d = 1'b1;
        end else if (!rv_q) begin
          if (arpc_pkg::cmd_e'(cmd_q) == arpc_pkg::CMD_QUEUE) begin
            if (!found_q) begin
              if (free_q == (PW+1)'(PENDING_ENTRIES)) stat_d = 1'b1;
              else begin
                pw_en = 1'b1; pw_a = free_q[PW-1:0]; pw_try = '0;
                p_vld_d[free_q[PW-1:0]] = 1'b1;
              end
            end
            state_d = arpc_pkg::ST_REPLY;
          end else begin
            if (found_q) begin
              p_vld_d[free_q[PW-1:0]] = 1'b0; hit_d = 1'b1;
            end
            idx_d = '0;
            state_d = arpc_pkg::ST_CACHE;
          end
        end
      end
      arpc_pkg::ST_CACHE: begin
        if (rv_q) begin
          case (arpc_pkg::cmd_e'(cmd_q))
            arpc_pkg::CMD_LOOKUP: begin
              if (c_vld_q[ridx_q[CW-1:0]] && rd_cip_q == ip_q) begin
                found_d = 1'b1; fmac_d = rd_cmac_q;
              end
            end
            arpc_pkg::CMD_TICK: begin
              if (c_vld_q[ridx_q[CW-1:0]] && (now_q - rd_cadd_q) > {16'd0, timeout})
                c_vld_d[ridx_q[CW-1:0]] = 1'b0;
            end
            default: ;
          endcase
        end
        if (arpc_pkg::cmd_e'(cmd_q) == arpc_pkg::CMD_INSERT) begin
          if (!c_vld_q[idx_q[CW-1:0]] && cfree_q == (CW+1)'(CACHE_ENTRIES) &&
              idx_q < (IW+1)'(CACHE_ENTRIES))
            cfree_d = idx_q[CW:0];
        end
        if (idx_q < (IW+1)'(CACHE_ENTRIES)) begin
          idx_d = idx_q + (IW+1)'(1); rv_d = 1'b1;
        end else if (!rv_q) begin
          if (arpc_pkg::cmd_e'(cmd_q) == arpc_pkg::CMD_INSERT) begin
            if (cfree_q == (CW+1)'(CACHE_ENTRIES)) stat_d = 1'b1;
            else begin
              cw_en = 1'b1; cw_a = cfree_q[CW-1:0];
              c_vld_d[cfree_q[CW-1:0]] = 1'b1;
            end
            state_d = arpc_pkg::ST_REPLY;
          end else if (arpc_pkg::cmd_e'(cmd_q) == arpc_pkg::CMD_TICK) begin
            idx_d = '0;
            state_d = arpc_pkg::ST_TPEND;
          end else begin
            state_d = arpc_pkg::ST_REPLY;
          end
        end
      end
      arpc_pkg::ST_TPEND: begin
        if (rv_q && p_vld_q[ridx_q[PW-1:0]]) begin
          res_d.valid = 1'b1; res_d.ip = rd_pip_q;
          if (rd_ptry_q >= max_tries) begin
            res_d.kind = arpc_pkg::KIND_GIVEUP;
            p_vld_d[ridx_q[PW-1:0]] = 1'b0;
          end else begin
            res_d.kind = arpc_pkg::KIND_RESEND;
            pw_en = 1'b1; pw_a = ridx_q[PW-1:0]; pw_ip = rd_pip_q;
            pw_try = rd_ptry_q + 8'd1;
          end
        end
        if (idx_q < (IW+1)'(PENDING_ENTRIES)) begin
          idx_d = idx_q + (IW+1)'(1); rv_d = 1'b1;
        end else if (!rv_q) begin
          state_d = arpc_pkg::ST_REPLY;
        end
      end
      arpc_pkg::ST_REPLY: begin
        res_d.valid = 1'b1; res_d.last = 1'b1;
        case (arpc_pkg::cmd_e'(cmd_q))
          arpc_pkg::CMD_LOOKUP: begin
            res_d.kind = arpc_pkg::KIND_LOOKUP; res_d.ip = ip_q;
            res_d.hit = found_q; res_d.mac = found_q ? fmac_q : 48'd0;
          end
          arpc_pkg::CMD_QUEUE: begin
            res_d.kind = arpc_pkg::KIND_QACK; res_d.ip = ip_q; res_d.status = stat_q;
          end
          arpc_pkg::CMD_INSERT: begin
            res_d.kind = arpc_pkg::KIND_IACK; res_d.ip = ip_q;
            res_d.hit = hit_q; res_d.status = stat_q;
          end
          default: res_d.kind = arpc_pkg::KIND_TICK;
        endcase
        state_d = arpc_pkg::ST_IDLE;
      end
      default: state_d = arpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::ST_IDLE;
      now_q <= '0; c_vld_q <= '0; p_vld_q <= '0; rv_q <= 1'b0; idx_q <= '0;
      res_q <= '0;
    end else begin
      state_q <= state_d; now_q <= now_d; c_vld_q <= c_vld_d; p_vld_q <= p_vld_d;
      rv_q <= rv_d; idx_q <= idx_d; res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ip_q <= ip_d; mac_q <= mac_d; ridx_q <= ridx_d;
    hit_q <= hit_d; stat_q <= stat_d; found_q <= found_d; fmac_q <= fmac_d;
    free_q <= free_d; cfree_q <= cfree_d;
  end

  assign result_valid_o = res_q.valid;
  assign kind_o         = res_q.kind;
  assign hit_o          = res_q.hit;
  assign result_ip_o    = res_q.ip;
  assign result_mac_o   = res_q.mac;
  assign status_o       = res_q.status;
  assign last_o         = res_q.last;

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arpc_pkg::ST_REPLY) |=> (result_valid_o && last_o && !busy))
    else $error("last result not followed by idle");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && start) |=> $stable(cmd_q))
    else $error("command changed while busy");
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("partial result while idle");
endmodule
